@@ rtl/hgt_pkg.sv @@
// ----------------------------------------------------------------------------
// hgt_pkg: shared types and constants of the heightfield grid tessellator
// Configuration register codes, the configuration bundle and the cell
// record that travels from the front end to the vertex back end.
// ----------------------------------------------------------------------------
`default_nettype none

package hgt_pkg;

	// default line buffer depth (samples per row)
	localparam int MAX_COLUMNS_DEF = 1024;

	// grid indices are carried at row-index width
	localparam int IDX_W = 16;

	// depth of the cell queue between front and back
	localparam int Q_DEPTH = 4;

	// configuration register codes
	typedef enum logic [2:0] {
		CFG_GRID_COLUMNS = 3'd0,
		CFG_GRID_ROWS    = 3'd1,
		CFG_X_ORIGIN     = 3'd2,
		CFG_X_STEP       = 3'd3,
		CFG_Z_ORIGIN     = 3'd4,
		CFG_Z_STEP       = 3'd5
	} cfg_reg_t;

	// configuration registers as seen by front and back
	typedef struct packed {
		logic        [10:0] grid_columns;
		logic        [15:0] grid_rows;
		logic signed [31:0] x_origin;
		logic signed [31:0] x_step;
		logic signed [31:0] z_origin;
		logic signed [31:0] z_step;
	} cfg_t;

	// one completed cell: four corner heights and its lower-right indices
	typedef struct packed {
		logic signed [31:0]  upper_left;
		logic signed [31:0]  lower_left;
		logic signed [31:0]  upper_right;
		logic signed [31:0]  lower_right;
		logic [IDX_W-1:0]    col;
		logic [IDX_W-1:0]    row;
		logic                grid_done;
	} cell_t;

endpackage

`default_nettype wire

@@ rtl/hgt_front.sv @@
// ----------------------------------------------------------------------------
// hgt_front: sample intake and cell classification
// Tracks the raster position, keeps the previous row in a line buffer and
// the left and upper-left neighbours, and hands completed cells onwards.
// ----------------------------------------------------------------------------
`default_nettype none

module hgt_front #(
	parameter int MAX_COLUMNS = hgt_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hgt_pkg::cfg_t      cfg,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] height,
	input  wire logic               q_full,
	output logic                    enq,
	output hgt_pkg::cell_t          enq_cell
);
	import hgt_pkg::*;

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	logic [CW-1:0]      col_q;
	logic [IDX_W-1:0]   row_q;
	logic signed [31:0] left_q;
	logic signed [31:0] upper_left_q;

	logic               valid_s1;
	logic               emit_s1;
	logic               grid_done_s1;
	logic [CW-1:0]      col_s1;
	logic [IDX_W-1:0]   row_s1;
	logic signed [31:0] height_s1;
	logic signed [31:0] up_s1;

	logic signed [31:0] line_mem [MAX_COLUMNS];

	logic [31:0]      cols_w;
	logic [CW-1:0]    cols_m1;
	logic [IDX_W-1:0] rows_m1;
	logic [CW-1:0]    col;
	logic             row_done;
	logic             grid_done;
	logic             accept;
	logic             retire;

	// clamp the counts and the column index
	always_comb begin
		cols_w = 32'(cfg.grid_columns);
		if (cols_w < 32'd2) begin
			cols_m1 = CW'(1);
		end else if (cols_w > 32'(MAX_COLUMNS)) begin
			cols_m1 = CW'(MAX_COLUMNS - 1);
		end else begin
			cols_m1 = CW'(cols_w - 32'd1);
		end
		rows_m1   = (cfg.grid_rows < 16'd2) ? 16'd1 : (cfg.grid_rows - 16'd1);
		col       = (col_q > cols_m1) ? cols_m1 : col_q;
		row_done  = (col == cols_m1);
		grid_done = row_done && (row_q >= rows_m1);
	end

	// handshake: stall only while a cell waits on a full queue
	assign full   = valid_s1 && emit_s1 && q_full;
	assign accept = push && !full;
	assign retire = valid_s1 && !(emit_s1 && q_full);
	assign enq    = valid_s1 && emit_s1 && !q_full;

	// raster position and neighbour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			left_q       <= '0;
			upper_left_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (accept) begin
				if (row_done) begin
					col_q <= '0;
					row_q <= grid_done ? '0 : (row_q + 16'd1);
				end else begin
					col_q <= col + CW'(1);
				end
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				upper_left_q <= up_s1;
				left_q       <= height_s1;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1      <= (row_q != '0) && (col != '0);
			grid_done_s1 <= grid_done;
			col_s1       <= col;
			row_s1       <= row_q;
			height_s1    <= height;
		end
	end

	// line buffer: read old entry, write the new sample at the same slot
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1         <= line_mem[col];
			line_mem[col] <= height;
		end
	end

	// cell record for the queue
	always_comb begin
		enq_cell.upper_left  = upper_left_q;
		enq_cell.lower_left  = left_q;
		enq_cell.upper_right = up_s1;
		enq_cell.lower_right = height_s1;
		enq_cell.col         = IDX_W'(col_s1);
		enq_cell.row         = row_s1;
		enq_cell.grid_done   = grid_done_s1;
	end

endmodule

`default_nettype wire

@@ rtl/hgt_queue.sv @@
// ----------------------------------------------------------------------------
// hgt_queue: cell queue between front and back
// Small register FIFO; lets the front keep taking samples while the back
// is still emitting vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module hgt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           enq,
	input  wire hgt_pkg::cell_t enq_cell,
	output logic                q_full,
	input  wire logic           deq,
	output logic                q_valid,
	output hgt_pkg::cell_t      head_cell
);
	import hgt_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	cell_t         slot_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign q_full    = (count_q == (PW+1)'(Q_DEPTH));
	assign q_valid   = (count_q != '0);
	assign head_cell = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (enq && !deq) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (deq && !enq) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= enq_cell;
		end
	end

endmodule

`default_nettype wire

@@ rtl/hgt_back.sv @@
// ----------------------------------------------------------------------------
// hgt_back: coordinate pipeline and vertex sequencer
// Scales grid indices by the step, adds the origin with saturation, then
// walks the six vertices of each cell into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hgt_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hgt_pkg::cfg_t  cfg,
	input  wire logic           q_valid,
	input  wire hgt_pkg::cell_t head_cell,
	output logic                deq,
	output logic                empty,
	input  wire logic           pop,
	output logic signed [31:0]  vert_x,
	output logic signed [31:0]  vert_y,
	output logic signed [31:0]  vert_z,
	output logic                triangle_end,
	output logic                last,
	output logic                grid_end
);
	import hgt_pkg::*;

	typedef enum logic [2:0] {
		V_UL,
		V_LL_A,
		V_UR_A,
		V_UR_B,
		V_LL_B,
		V_LR
	} vtx_t;

	// saturate a 50-bit sum to signed 32 bits
	function automatic logic [31:0] sat32(input logic [49:0] v);
		logic [31:0] r;
		if ((v[49:31] == '0) || (v[49:31] == '1)) begin
			r = v[31:0];
		end else if (v[49]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	// stage A: products
	logic               a_valid_q;
	cell_t              a_cell_q;
	logic signed [48:0] px0_q, px1_q, pz0_q, pz1_q;
	logic [IDX_W-1:0]   col_m1;
	logic [IDX_W-1:0]   row_m1;

	// stage B: saturated coordinates
	logic               b_valid_q;
	cell_t              b_cell_q;
	logic [31:0]        x0_b_q, x1_b_q, z0_b_q, z1_b_q;

	// stage C: cell under emission
	logic               c_valid_q;
	cell_t              c_cell_q;
	logic [31:0]        x0_c_q, x1_c_q, z0_c_q, z1_c_q;
	vtx_t               phase_q;

	logic               out_valid_q;
	logic               out_load;
	logic               ready_a, ready_b, ready_c;

	logic [31:0]        vx, vy, vz;
	logic               te, lst, ge;
	vtx_t               phase_nxt;

	// pipeline flow
	assign empty    = !out_valid_q;
	assign out_load = c_valid_q && (!out_valid_q || pop);
	assign ready_c  = !c_valid_q || (out_load && (phase_q == V_LR));
	assign ready_b  = !b_valid_q || ready_c;
	assign ready_a  = !a_valid_q || ready_b;
	assign deq      = q_valid && ready_a;

	assign col_m1 = head_cell.col - IDX_W'(1);
	assign row_m1 = head_cell.row - IDX_W'(1);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
			c_valid_q <= 1'b0;
		end else begin
			if (ready_a) begin
				a_valid_q <= q_valid;
			end
			if (ready_b) begin
				b_valid_q <= a_valid_q;
			end
			if (ready_c) begin
				c_valid_q <= b_valid_q;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (deq) begin
			a_cell_q <= head_cell;
			px0_q    <= $signed({1'b0, col_m1}) * cfg.x_step;
			px1_q    <= $signed({1'b0, head_cell.col}) * cfg.x_step;
			pz0_q    <= $signed({1'b0, row_m1}) * cfg.z_step;
			pz1_q    <= $signed({1'b0, head_cell.row}) * cfg.z_step;
		end
		if (ready_b && a_valid_q) begin
			b_cell_q <= a_cell_q;
			x0_b_q   <= sat32({{18{cfg.x_origin[31]}}, cfg.x_origin} + {px0_q[48], px0_q});
			x1_b_q   <= sat32({{18{cfg.x_origin[31]}}, cfg.x_origin} + {px1_q[48], px1_q});
			z0_b_q   <= sat32({{18{cfg.z_origin[31]}}, cfg.z_origin} + {pz0_q[48], pz0_q});
			z1_b_q   <= sat32({{18{cfg.z_origin[31]}}, cfg.z_origin} + {pz1_q[48], pz1_q});
		end
		if (ready_c && b_valid_q) begin
			c_cell_q <= b_cell_q;
			x0_c_q   <= x0_b_q;
			x1_c_q   <= x1_b_q;
			z0_c_q   <= z0_b_q;
			z1_c_q   <= z1_b_q;
		end
	end

	// vertex selection per phase
	always_comb begin
		vx        = x0_c_q;
		vy        = c_cell_q.upper_left;
		vz        = z0_c_q;
		te        = 1'b0;
		lst       = 1'b0;
		ge        = 1'b0;
		phase_nxt = V_UL;
		unique case (phase_q)
			V_UL: begin
				phase_nxt = V_LL_A;
			end
			V_LL_A: begin
				vy        = c_cell_q.lower_left;
				vz        = z1_c_q;
				phase_nxt = V_UR_A;
			end
			V_UR_A: begin
				vx        = x1_c_q;
				vy        = c_cell_q.upper_right;
				te        = 1'b1;
				phase_nxt = V_UR_B;
			end
			V_UR_B: begin
				vx        = x1_c_q;
				vy        = c_cell_q.upper_right;
				phase_nxt = V_LL_B;
			end
			V_LL_B: begin
				vy        = c_cell_q.lower_left;
				vz        = z1_c_q;
				phase_nxt = V_LR;
			end
			V_LR: begin
				vx        = x1_c_q;
				vy        = c_cell_q.lower_right;
				vz        = z1_c_q;
				te        = 1'b1;
				lst       = 1'b1;
				ge        = c_cell_q.grid_done;
				phase_nxt = V_UL;
			end
			default: begin
				phase_nxt = V_UL;
			end
		endcase
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= V_UL;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				phase_q      <= phase_nxt;
				out_valid_q  <= 1'b1;
				vert_x       <= vx;
				vert_y       <= vy;
				vert_z       <= vz;
				triangle_end <= te;
				last         <= lst;
				grid_end     <= ge;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/heightfield_grid_tessellator_unit.sv @@
// ----------------------------------------------------------------------------
// heightfield_grid_tessellator_unit: heightfield grid to triangle vertices
// Configuration registers, sample front end, cell queue and vertex back end.
// ----------------------------------------------------------------------------
// Path: a cell's first vertex goes through front stage 1, the cell queue, back-end
//   stages A, B and C and the result register; the other five follow one a cycle.
// Throughput: one vertex per cycle from the back-end sequencer while the receiver
//   pops, six per interior sample; first-row and first-column samples emit none.
// Reset: asynchronous, clears configuration to defaults, raster position,
//   neighbours and queues; the line buffer is not cleared.
`default_nettype none

module heightfield_grid_tessellator_unit #(
	parameter int MAX_COLUMNS = hgt_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] height,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      vert_x,
	output logic signed [31:0]      vert_y,
	output logic signed [31:0]      vert_z,
	output logic                    triangle_end,
	output logic                    last,
	output logic                    grid_end
);
	import hgt_pkg::*;

	cfg_t  cfg_q;
	logic  enq, q_full, q_valid, deq;
	cell_t enq_cell, head_cell;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_columns <= 11'd2;
			cfg_q.grid_rows    <= 16'd2;
			cfg_q.x_origin     <= 32'sd0;
			cfg_q.x_step       <= 32'sd65536;
			cfg_q.z_origin     <= 32'sd0;
			cfg_q.z_step       <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GRID_COLUMNS: cfg_q.grid_columns <= cfg_data[10:0];
				CFG_GRID_ROWS:    cfg_q.grid_rows    <= cfg_data[15:0];
				CFG_X_ORIGIN:     cfg_q.x_origin     <= cfg_data;
				CFG_X_STEP:       cfg_q.x_step       <= cfg_data;
				CFG_Z_ORIGIN:     cfg_q.z_origin     <= cfg_data;
				CFG_Z_STEP:       cfg_q.z_step       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hgt_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.height   (height),
		.q_full   (q_full),
		.enq      (enq),
		.enq_cell (enq_cell)
	);

	hgt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_cell  (enq_cell),
		.q_full    (q_full),
		.deq       (deq),
		.q_valid   (q_valid),
		.head_cell (head_cell)
	);

	hgt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.head_cell    (head_cell),
		.deq          (deq),
		.empty        (empty),
		.pop          (pop),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.vert_z       (vert_z),
		.triangle_end (triangle_end),
		.last         (last),
		.grid_end     (grid_end)
	);

endmodule

`default_nettype wire

@@ test/heightfield_grid_tessellator_unit_test.sv @@
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// heightfield_grid_tessellator_unit_test: vertex stream check of the tessellator
// Height samples go in by push/full and vertices come out by empty/pop. A
// scoreboard class keeps its own line buffer, neighbours and raster position,
// works out the six vertices of every completed cell and compares each
// popped beat field by field. Directed grids cover the register extremes and
// mid-grid size changes, one sweep starts a row wider than the buffer and
// cuts it short, and random grids follow under three idle mixes with one
// long receiver hold-off.
// ----------------------------------------------------------------------------

module heightfield_grid_tessellator_unit_test;
	import hgt_pkg::*;

	localparam int          RESET_CYCLES    = 12;
	localparam int          DRAIN_CYCLES    = 12;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          CYCLE_LIMIT     = 400000;
	localparam int          BUF_DEPTH       = MAX_COLUMNS_DEF;
	localparam int          PHASE_ITEMS     = 90;
	localparam int          PRESSURE_ITEMS  = 48;
	localparam int          SWEEP_ITEMS     = 24;
	localparam int          CUT_COLUMNS     = 12;
	localparam logic [2:0]  CFG_SPARE_LO    = 3'd6;
	localparam logic [2:0]  CFG_SPARE_HI    = 3'd7;
	localparam logic [31:0] Q_MAX           = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN           = 32'h8000_0000;
	localparam logic [31:0] Q_ONE           = 32'h0001_0000;
	localparam longint      SAT_HI          = 64'sd2147483647;
	localparam longint      SAT_LO          = -64'sd2147483648;

	// one vertex beat as seen on the result ports
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        tri_end;
		logic        cell_last;
		logic        grid_end;
	} vertex_t;

	// ------------------------------------------------------------------
	// scoreboard: own copy of registers, line buffer and raster position
	// ------------------------------------------------------------------
	class tessellation_scoreboard;
		logic [10:0] grid_columns;
		logic [15:0] grid_rows;
		logic [31:0] x_origin;
		logic [31:0] x_step;
		logic [31:0] z_origin;
		logic [31:0] z_step;
		logic [31:0] line_buf [BUF_DEPTH];
		logic [31:0] left_h;
		logic [31:0] upper_left_h;
		int unsigned col_idx;
		int unsigned row_idx;
		int unsigned written_span;
		int unsigned mismatches;
		vertex_t     cell_verts [$];

		function new();
			grid_columns = 11'd2;
			grid_rows    = 16'd2;
			x_origin     = '0;
			x_step       = Q_ONE;
			z_origin     = '0;
			z_step       = Q_ONE;
			foreach (line_buf[i])
				line_buf[i] = '0;
			left_h       = '0;
			upper_left_h = '0;
			col_idx      = 0;
			row_idx      = 0;
			written_span = 0;
			mismatches   = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] data);
			case (idx)
				CFG_GRID_COLUMNS: grid_columns = data[10:0];
				CFG_GRID_ROWS:    grid_rows    = data[15:0];
				CFG_X_ORIGIN:     x_origin     = data;
				CFG_X_STEP:       x_step       = data;
				CFG_Z_ORIGIN:     z_origin     = data;
				CFG_Z_STEP:       z_step       = data;
				default: ;
			endcase
		endfunction

		// origin + index * step, clipped to the signed 32-bit range
		function logic [31:0] grid_coord(logic [31:0] origin, logic [31:0] step,
				int unsigned idx);
			longint sum;
			sum = longint'(signed'(origin)) + longint'(idx) * longint'(signed'(step));
			if (sum > SAT_HI)
				return Q_MAX;
			if (sum < SAT_LO)
				return Q_MIN;
			return sum[31:0];
		endfunction

		function void expect_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
				logic te, logic cl, logic ge);
			vertex_t v;
			v.x         = x;
			v.y         = y;
			v.z         = z;
			v.tri_end   = te;
			v.cell_last = cl;
			v.grid_end  = ge;
			cell_verts.push_back(v);
		endfunction

		// one accepted sample: emit the cell it closes, then advance
		function void note_sample(logic [31:0] h);
			int unsigned cols, rows, col;
			logic [31:0] up, x0, x1, z0, z1;
			bit          row_done, grid_done;
			cols = grid_columns;
			if (cols < 2)
				cols = 2;
			if (cols > BUF_DEPTH)
				cols = BUF_DEPTH;
			rows = grid_rows;
			if (rows < 2)
				rows = 2;
			col = col_idx;
			if (col > cols - 1)
				col = cols - 1;
			up        = line_buf[col];
			row_done  = (col >= cols - 1);
			grid_done = row_done && (row_idx >= rows - 1);

			if (row_idx >= 1 && col >= 1) begin
				x0 = grid_coord(x_origin, x_step, col - 1);
				x1 = grid_coord(x_origin, x_step, col);
				z0 = grid_coord(z_origin, z_step, row_idx - 1);
				z1 = grid_coord(z_origin, z_step, row_idx);
				expect_vertex(x0, upper_left_h, z0, 1'b0, 1'b0, 1'b0);
				expect_vertex(x0, left_h,       z1, 1'b0, 1'b0, 1'b0);
				expect_vertex(x1, up,           z0, 1'b1, 1'b0, 1'b0);
				expect_vertex(x1, up,           z0, 1'b0, 1'b0, 1'b0);
				expect_vertex(x0, left_h,       z1, 1'b0, 1'b0, 1'b0);
				expect_vertex(x1, h,            z1, 1'b1, 1'b1, grid_done);
			end

			upper_left_h  = up;
			left_h        = h;
			line_buf[col] = h;
			if (col + 1 > written_span)
				written_span = col + 1;

			if (row_done) begin
				col_idx = 0;
				row_idx = grid_done ? 0 : ((row_idx + 1) & 32'hFFFF);
			end else begin
				col_idx = col + 1;
			end
		endfunction

		function int unsigned pending();
			return cell_verts.size();
		endfunction

		function bit at_grid_start();
			return row_idx == 0 && col_idx == 0;
		endfunction

		// past row zero, a wider row would read buffer slots never filled
		function int unsigned widest_safe_columns();
			return (row_idx == 0) ? 2047 : written_span;
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] vertex check: %s", $time, what);
		endtask

		task check_vertex(vertex_t got);
			vertex_t want;
			if (cell_verts.size() == 0) begin
				report($sformatf("unexpected beat x=%h y=%h z=%h", got.x, got.y, got.z));
				return;
			end
			want = cell_verts.pop_front();
			if (got.x !== want.x)
				report($sformatf("vert_x %h, expected %h", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("vert_y %h, expected %h", got.y, want.y));
			if (got.z !== want.z)
				report($sformatf("vert_z %h, expected %h", got.z, want.z));
			if (got.tri_end !== want.tri_end)
				report($sformatf("triangle_end %b, expected %b", got.tri_end, want.tri_end));
			if (got.cell_last !== want.cell_last)
				report($sformatf("last %b, expected %b", got.cell_last, want.cell_last));
			if (got.grid_end !== want.grid_end)
				report($sformatf("grid_end %b, expected %b", got.grid_end, want.grid_end));
		endtask
	endclass

	// ------------------------------------------------------------------
	// signals and block under test
	// ------------------------------------------------------------------
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic [2:0]  cfg_index   = '0;
	logic [31:0] cfg_data    = '0;
	logic        push        = 1'b0;
	logic [31:0] height      = '0;
	logic        pop         = 1'b0;
	logic        rx_hold     = 1'b0;
	logic        pressure_go = 1'b0;
	int unsigned tx_idle_pct = 14;
	int unsigned rx_idle_pct = 77;
	int unsigned cycle_count = 0;

	logic        cfg_ready;
	logic        full;
	logic        empty;
	logic [31:0] vert_x;
	logic [31:0] vert_y;
	logic [31:0] vert_z;
	logic        triangle_end;
	logic        last;
	logic        grid_end;

	tessellation_scoreboard sb;

	heightfield_grid_tessellator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.height       (height),
		.empty        (empty),
		.pop          (pop),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.vert_z       (vert_z),
		.triangle_end (triangle_end),
		.last         (last),
		.grid_end     (grid_end)
	);

	// clock
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random pop, forced low during a hold-off
	always @(negedge clk) begin
		pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// result beats go to the scoreboard
	always @(posedge clk) begin : vertex_sampler
		vertex_t seen;
		if (arst_n && pop && !empty) begin
			seen.x         = vert_x;
			seen.y         = vert_y;
			seen.z         = vert_z;
			seen.tri_end   = triangle_end;
			seen.cell_last = last;
			seen.grid_end  = grid_end;
			sb.check_vertex(seen);
		end
	end

	// long receiver hold-off so the block backs up to its input
	initial begin
		wait (pressure_go);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic [31:0] h);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push   <= 1'b1;
		height <= h;
		do @(posedge clk); while (full);
		sb.note_sample(h);
	endtask

	// stop offering, let every expected beat drain, then allow for latency
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] random_height();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			1: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] random_coord();
		logic [31:0] mag;
		mag = $urandom_range(0, 32'h0004_0000);
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			1, 2: return $urandom_range(0, 1) ? -mag : mag;
			default: return $urandom();
		endcase
	endfunction

	// new grid size and coordinates; upper data bits are junk on purpose
	task automatic reconfigure();
		int unsigned cols, rows, pick;
		logic [31:0] data;
		settle();
		pick = $urandom_range(0, 99);
		if (pick < 6)
			cols = $urandom_range(0, 1);
		else if (pick < 85)
			cols = $urandom_range(2, 6);
		else
			cols = $urandom_range(7, 16);
		if (cols > sb.widest_safe_columns())
			cols = sb.widest_safe_columns();
		pick = $urandom_range(0, 99);
		if (pick < 6)
			rows = $urandom_range(0, 1);
		else if (pick < 12)
			rows = $urandom_range(16'hFF00, 16'hFFFF);
		else
			rows = $urandom_range(2, 5);

		data       = $urandom();
		data[10:0] = cols[10:0];
		write_reg(CFG_GRID_COLUMNS, data);
		data       = $urandom();
		data[15:0] = rows[15:0];
		write_reg(CFG_GRID_ROWS, data);
		if ($urandom_range(0, 9) < 7)
			write_reg(CFG_X_ORIGIN, random_coord());
		if ($urandom_range(0, 9) < 7)
			write_reg(CFG_X_STEP, random_coord());
		if ($urandom_range(0, 9) < 7)
			write_reg(CFG_Z_ORIGIN, random_coord());
		if ($urandom_range(0, 9) < 7)
			write_reg(CFG_Z_STEP, random_coord());
	endtask

	// ------------------------------------------------------------------
	// stimulus sections
	// ------------------------------------------------------------------
	task automatic directed_grids();
		// reset geometry, one cell, height extremes
		send_sample(Q_MIN);
		send_sample(Q_MAX);
		send_sample(32'h0);
		send_sample(32'hFFFF_FFFF);
		settle();

		// counts below minimum, coordinates saturating both ways, spare codes
		write_reg(CFG_GRID_COLUMNS, {21'h1F_FFFF, 11'd0});
		write_reg(CFG_GRID_ROWS, {16'hFFFF, 16'd1});
		write_reg(CFG_X_ORIGIN, Q_MAX);
		write_reg(CFG_X_STEP, Q_MAX);
		write_reg(CFG_Z_ORIGIN, Q_MIN);
		write_reg(CFG_Z_STEP, Q_MIN);
		write_reg(CFG_SPARE_LO, $urandom());
		write_reg(CFG_SPARE_HI, $urandom());
		send_sample(32'hAAAA_AAAA);
		send_sample(32'h5555_5555);
		send_sample(32'h1234_5678);
		send_sample(32'hEDCB_A988);
		settle();

		// 3x3 grid with negative X spacing
		write_reg(CFG_GRID_COLUMNS, 32'd3);
		write_reg(CFG_GRID_ROWS, 32'd3);
		write_reg(CFG_X_ORIGIN, 32'hFFFF_0000);
		write_reg(CFG_X_STEP, 32'hFFFF_FFFF);
		write_reg(CFG_Z_ORIGIN, 32'h0003_0000);
		write_reg(CFG_Z_STEP, 32'h0000_8000);
		repeat (9) send_sample(random_height());
		settle();

		// near-endless grid cut short: columns shrink below the column
		// index and rows drop to the current row, so one more sample
		// closes the row and the grid together
		write_reg(CFG_GRID_ROWS, 32'd65535);
		repeat (5) send_sample(random_height());
		settle();
		write_reg(CFG_GRID_COLUMNS, 32'd2);
		write_reg(CFG_GRID_ROWS, 32'd2);
		send_sample(random_height());
		settle();
	endtask

	// columns above the buffer depth clamp to it; part of a first row goes
	// in, then the row is cut short and the second row closes its cells
	task automatic long_row_sweep();
		logic [31:0] data;
		data       = $urandom();
		data[10:0] = 11'h7FF;
		write_reg(CFG_GRID_COLUMNS, data);
		write_reg(CFG_GRID_ROWS, 32'd2);
		write_reg(CFG_X_STEP, 32'h0000_4000);
		repeat (SWEEP_ITEMS) send_sample(random_height());
		settle();
		write_reg(CFG_GRID_COLUMNS, 32'(CUT_COLUMNS));
		repeat (CUT_COLUMNS + 2) send_sample(random_height());
		reconfigure();
	endtask

	// mostly whole grids; now and then a grid is cut by a new setting
	task automatic random_phase(input int unsigned n_items);
		int unsigned sent, countdown;
		sent      = 0;
		countdown = $urandom_range(8, 40);
		while (sent < n_items) begin
			if (countdown == 0 && (sb.at_grid_start() || $urandom_range(0, 19) == 0)) begin
				reconfigure();
				countdown = $urandom_range(8, 40);
			end
			send_sample(random_height());
			sent++;
			if (countdown != 0)
				countdown--;
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_grids();
		long_row_sweep();
		random_phase(PHASE_ITEMS);

		settle();
		tx_idle_pct = 77;
		rx_idle_pct = 14;
		random_phase(PHASE_ITEMS);

		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// endless rows keep most samples closing a cell during the hold-off
		write_reg(CFG_GRID_ROWS, 32'd65535);
		pressure_go = 1'b1;
		repeat (PRESSURE_ITEMS) send_sample(random_height());
		random_phase(PHASE_ITEMS - PRESSURE_ITEMS);

		settle();
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/hgt_pkg.sv
rtl/hgt_front.sv
rtl/hgt_queue.sv
rtl/hgt_back.sv
rtl/heightfield_grid_tessellator_unit.sv
test/heightfield_grid_tessellator_unit_test.sv
